@@ rtl/ctta_pkg.sv @@
// ----------------------------------------------------------------------------
// ctta_pkg: shared types and constants for the turn-to-angle controller
// Register map, status codes, controller states, datapath operations and the
// fixed-point constants of the angle and rate loops.
// ----------------------------------------------------------------------------
package ctta_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_HEADING   = 3'd0,
    REG_SETTLE_THRESHOLD = 3'd1,
    REG_SETTLE_TICKS     = 3'd2,
    REG_TIMEOUT_TICKS    = 3'd3,
    REG_ANGLE_GAIN       = 3'd4,
    REG_RATE_PROP_GAIN   = 3'd5,
    REG_RATE_INT_GAIN    = 3'd6,
    REG_SPEED_LIMIT      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    TS_IDLE      = 3'd0,
    TS_TURNING   = 3'd1,
    TS_SETTLING  = 3'd2,
    TS_REACHED   = 3'd3,
    TS_TIMED_OUT = 3'd4
  } turn_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_EVAL,
    ST_TGT,
    ST_RERR,
    ST_FF,
    ST_PROP,
    ST_DIV10_MUL,
    ST_DIV10_FIX,
    ST_IMUL,
    ST_DIV100_MUL,
    ST_DIV100_FIX,
    ST_CLAMP,
    ST_SLEW,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEGIN,
    OP_IDLE_TICK,
    OP_TIMEOUT,
    OP_SETTLE,
    OP_TURN,
    OP_TGT,
    OP_RERR,
    OP_FF,
    OP_PROP,
    OP_DIV10_MUL,
    OP_DIV10_FIX,
    OP_IMUL,
    OP_DIV100_MUL,
    OP_DIV100_FIX,
    OP_CLAMP,
    OP_SLEW,
    OP_EMIT
  } dp_op_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic active;
    logic timeout;
    logic in_band;
    logic out_free;
  } dp_flags_t;

  localparam int HALF_TURN       = 18000;
  localparam int RATE_TARGET_MAX = 15000;
  localparam int ACCUM_LIMIT     = 300000;
  localparam int FF_MULT         = 62119;
  localparam int ACCEL_STEP      = 200;
  localparam int DECEL_STEP      = 400;
  localparam int MIN_SPEED       = 100;

  // Reciprocals for exact floor division of values below 2^32
  localparam logic [31:0] RECIP10        = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT  = 35;
  localparam logic [31:0] RECIP100       = 32'h51EB_851F;
  localparam int          RECIP100_SHIFT = 37;

endpackage

@@ rtl/ctta_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctta_ctrl: sequencer of the turn-to-angle controller
// Walks one tick through the datapath operations and holds the input side
// while a tick is in work.
// ----------------------------------------------------------------------------
module ctta_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctta_pkg::dp_flags_t flags,
  output ctta_pkg::dp_op_t    op
);
  import ctta_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        op         = OP_BEGIN;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_FINISH;
        if (!flags.active) begin
          op = OP_IDLE_TICK;
        end else if (flags.timeout) begin
          op = OP_TIMEOUT;
        end else if (flags.in_band) begin
          op = OP_SETTLE;
        end else begin
          op         = OP_TURN;
          state_next = ST_TGT;
        end
      end
      ST_TGT: begin
        op         = OP_TGT;
        state_next = ST_RERR;
      end
      ST_RERR: begin
        op         = OP_RERR;
        state_next = ST_FF;
      end
      ST_FF: begin
        op         = OP_FF;
        state_next = ST_PROP;
      end
      ST_PROP: begin
        op         = OP_PROP;
        state_next = ST_DIV10_MUL;
      end
      ST_DIV10_MUL: begin
        op         = OP_DIV10_MUL;
        state_next = ST_DIV10_FIX;
      end
      ST_DIV10_FIX: begin
        op         = OP_DIV10_FIX;
        state_next = ST_IMUL;
      end
      ST_IMUL: begin
        op         = OP_IMUL;
        state_next = ST_DIV100_MUL;
      end
      ST_DIV100_MUL: begin
        op         = OP_DIV100_MUL;
        state_next = ST_DIV100_FIX;
      end
      ST_DIV100_FIX: begin
        op         = OP_DIV100_FIX;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        op         = OP_CLAMP;
        state_next = ST_SLEW;
      end
      ST_SLEW: begin
        op         = OP_SLEW;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (flags.out_free) begin
          op         = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ctta_dp.sv @@
// ----------------------------------------------------------------------------
// ctta_dp: datapath of the turn-to-angle controller
// Configuration registers, turn state, one shared 27x33 multiplier with its
// product register, the loop arithmetic and the output register.
// ----------------------------------------------------------------------------
module ctta_dp #(
  parameter int TICK_MS      = 5,
  parameter int FILTER_SHIFT = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ctta_pkg::dp_op_t                     op,
  output ctta_pkg::dp_flags_t                  flags,
  input  logic                                 cfg_wr_en,
  input  logic [ctta_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctta_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 start_turn,
  input  logic signed [15:0]                   yaw_now,
  input  logic signed [18:0]                   rate_now,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [15:0]                   turn_command,
  output logic [2:0]                           turn_status
);
  import ctta_pkg::*;

  localparam logic signed [17:0] WRAP_HI  = 18'(HALF_TURN);
  localparam logic signed [17:0] WRAP_HI3 = 18'(3 * HALF_TURN);
  localparam logic signed [17:0] WRAP_ONE = 18'(2 * HALF_TURN);
  localparam logic signed [17:0] WRAP_TWO = 18'(4 * HALF_TURN);
  localparam logic signed [59:0] TGT_MAX  = 60'(RATE_TARGET_MAX);
  localparam logic signed [23:0] ACC_MAX  = 24'(ACCUM_LIMIT);
  localparam logic signed [17:0] STEP_UP  = 18'(ACCEL_STEP);
  localparam logic signed [17:0] STEP_DN  = 18'(DECEL_STEP);
  localparam logic signed [17:0] SPD_MIN  = 18'(MIN_SPEED);

  // configuration
  logic signed [15:0] target_heading;
  logic [9:0]         settle_threshold;
  logic [7:0]         settle_ticks;
  logic [15:0]        timeout_ticks;
  logic [11:0]        angle_gain;
  logic [11:0]        rate_prop_gain;
  logic [11:0]        rate_int_gain;
  logic [14:0]        speed_limit;

  // turn state
  logic signed [19:0] rate_filtered;
  logic signed [19:0] rate_accum;
  logic signed [15:0] previous_command;
  logic [7:0]         settle_counter;
  logic [15:0]        elapsed_ticks;
  logic               turn_active;

  // per-tick work registers
  logic               start_q;
  logic signed [15:0] yaw_q;
  logic signed [19:0] meas_q;
  logic signed [15:0] err;
  logic signed [15:0] tgt;
  logic signed [19:0] rerr;
  logic signed [59:0] prod;
  logic               div_neg;
  logic signed [23:0] spd_sum;
  logic signed [15:0] res_cmd;
  logic [2:0]         res_status;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading   <= '0;
      settle_threshold <= 10'd10;
      settle_ticks     <= 8'd10;
      timeout_ticks    <= 16'd400;
      angle_gain       <= 12'd768;
      rate_prop_gain   <= 12'd51;
      rate_int_gain    <= 12'd38;
      speed_limit      <= 15'd15000;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_HEADING:   target_heading   <= cfg_data;
        REG_SETTLE_THRESHOLD: settle_threshold <= cfg_data[9:0];
        REG_SETTLE_TICKS:     settle_ticks     <= cfg_data[7:0];
        REG_TIMEOUT_TICKS:    timeout_ticks    <= cfg_data;
        REG_ANGLE_GAIN:       angle_gain       <= cfg_data[11:0];
        REG_RATE_PROP_GAIN:   rate_prop_gain   <= cfg_data[11:0];
        REG_RATE_INT_GAIN:    rate_int_gain    <= cfg_data[11:0];
        REG_SPEED_LIMIT:      speed_limit      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- combinational
  logic signed [17:0] err_raw, err_wrap;
  logic [14:0]        err_mag;
  logic signed [20:0] filt_diff, filt_step, filt_sum;
  logic [7:0]         settle_inc;
  logic               settle_done;
  logic signed [59:0] prod_sh8, prod_sh16, div_src, div_ofs, div_abs;
  logic signed [59:0] prod_q10, prod_q100;
  logic [26:0]        div_mag;
  logic signed [23:0] q10_val, q100_val, acc_sum, spd_lim;
  logic signed [26:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [15:0] tgt_clamped;
  logic signed [20:0] rerr_wide;
  logic signed [19:0] accum_next;
  logic signed [16:0] spd17, prev17;
  logic signed [17:0] spd_abs, prev_abs, diff, step_lim, step, nxt, nxt_abs, slew_out;
  logic               opposite;

  always_comb begin
    // heading error wrapped into (-HALF_TURN, HALF_TURN]
    err_raw = 18'(target_heading) - 18'(yaw_q);
    if (err_raw > WRAP_HI3) begin
      err_wrap = err_raw - WRAP_TWO;
    end else if (err_raw > WRAP_HI) begin
      err_wrap = err_raw - WRAP_ONE;
    end else if (err_raw <= -WRAP_HI3) begin
      err_wrap = err_raw + WRAP_TWO;
    end else if (err_raw <= -WRAP_HI) begin
      err_wrap = err_raw + WRAP_ONE;
    end else begin
      err_wrap = err_raw;
    end

    err_mag = err[15] ? 15'(-err) : 15'(err);

    filt_diff = 21'(meas_q) - 21'(rate_filtered);
    filt_step = filt_diff >>> FILTER_SHIFT;
    filt_sum  = 21'(rate_filtered) + filt_step;

    settle_inc  = (settle_counter == 8'hFF) ? settle_counter : settle_counter + 8'd1;
    settle_done = (settle_inc >= settle_ticks);

    prod_sh8  = prod >>> 8;
    prod_sh16 = prod >>> 16;

    if (prod_sh8 > TGT_MAX) begin
      tgt_clamped = 16'(RATE_TARGET_MAX);
    end else if (prod_sh8 < -TGT_MAX) begin
      tgt_clamped = -16'(RATE_TARGET_MAX);
    end else begin
      tgt_clamped = prod_sh8[15:0];
    end
    rerr_wide = 21'(tgt) - 21'(rate_filtered);

    // floor division of a negative value through the magnitude plus divisor-1
    div_src = (op == OP_DIV100_MUL) ? prod_sh8 : prod;
    div_ofs = (op == OP_DIV100_MUL) ? 60'sd99 : 60'sd9;
    div_abs = div_src[59] ? (div_ofs - div_src) : div_src;
    div_mag = div_abs[26:0];

    prod_q10  = prod >>> RECIP10_SHIFT;
    prod_q100 = prod >>> RECIP100_SHIFT;
    q10_val   = div_neg ? -24'(prod_q10[22:0]) : 24'(prod_q10[22:0]);
    q100_val  = div_neg ? -24'(prod_q100[15:0]) : 24'(prod_q100[15:0]);

    acc_sum = 24'(rate_accum) + q10_val;
    if (acc_sum > ACC_MAX) begin
      accum_next = 20'(ACCUM_LIMIT);
    end else if (acc_sum < -ACC_MAX) begin
      accum_next = -20'(ACCUM_LIMIT);
    end else begin
      accum_next = acc_sum[19:0];
    end

    spd_lim = 24'(speed_limit);

    // slew: accelerate by at most STEP_UP, otherwise move by at most STEP_DN; keep at least MIN_SPEED
    spd17    = spd_sum[16:0];
    prev17   = 17'(previous_command);
    spd_abs  = spd17[16] ? -18'(spd17) : 18'(spd17);
    prev_abs = prev17[16] ? -18'(prev17) : 18'(prev17);
    opposite = (spd17 < 0 && prev17 > 0) || (spd17 > 0 && prev17 < 0);
    step_lim = (!opposite && spd_abs > prev_abs) ? STEP_UP : STEP_DN;
    diff     = 18'(spd17) - 18'(prev17);
    if (diff > step_lim) begin
      step = step_lim;
    end else if (diff < -step_lim) begin
      step = -step_lim;
    end else begin
      step = diff;
    end
    nxt     = 18'(prev17) + step;
    nxt_abs = nxt[17] ? -nxt : nxt;
    if (nxt_abs < SPD_MIN) begin
      slew_out = (err > 0) ? SPD_MIN : -SPD_MIN;
    end else begin
      slew_out = nxt;
    end

    // shared multiplier operands
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_TURN: begin
        mul_a = 27'(err);
        mul_b = 33'(angle_gain);
      end
      OP_RERR: begin
        mul_a = 27'(tgt);
        mul_b = 33'(FF_MULT);
      end
      OP_FF: begin
        mul_a = 27'(rerr);
        mul_b = 33'(rate_prop_gain);
      end
      OP_PROP: begin
        mul_a = 27'(rerr);
        mul_b = 33'(TICK_MS);
      end
      OP_DIV10_MUL: begin
        mul_a = div_mag;
        mul_b = 33'(RECIP10);
      end
      OP_IMUL: begin
        mul_a = 27'(rate_accum);
        mul_b = 33'(rate_int_gain);
      end
      OP_DIV100_MUL: begin
        mul_a = div_mag;
        mul_b = 33'(RECIP100);
      end
      default: ;
    endcase
  end

  assign flags.active   = turn_active;
  assign flags.timeout  = (elapsed_ticks >= timeout_ticks);
  assign flags.in_band  = (err_mag <= 15'(settle_threshold));
  assign flags.out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------- turn state
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_filtered    <= '0;
      rate_accum       <= '0;
      previous_command <= '0;
      settle_counter   <= '0;
      elapsed_ticks    <= '0;
      turn_active      <= 1'b0;
    end else begin
      case (op)
        OP_BEGIN: begin
          if (start_q) begin
            rate_filtered    <= meas_q;
            rate_accum       <= '0;
            previous_command <= '0;
            settle_counter   <= '0;
            elapsed_ticks    <= '0;
            turn_active      <= 1'b1;
          end
        end
        OP_TIMEOUT: begin
          turn_active <= 1'b0;
        end
        OP_SETTLE: begin
          elapsed_ticks    <= elapsed_ticks + 16'd1;
          rate_filtered    <= filt_sum[19:0];
          settle_counter   <= settle_inc;
          previous_command <= '0;
          if (settle_done) begin
            turn_active <= 1'b0;
          end
        end
        OP_TURN: begin
          elapsed_ticks  <= elapsed_ticks + 16'd1;
          rate_filtered  <= filt_sum[19:0];
          settle_counter <= '0;
        end
        OP_DIV10_FIX: begin
          rate_accum <= accum_next;
        end
        OP_SLEW: begin
          previous_command <= slew_out[15:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- work registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        start_q <= start_turn;
        yaw_q   <= yaw_now;
        meas_q  <= -20'(rate_now);
      end
      OP_BEGIN: begin
        err <= err_wrap[15:0];
      end
      OP_IDLE_TICK: begin
        res_cmd    <= '0;
        res_status <= TS_IDLE;
      end
      OP_TIMEOUT: begin
        res_cmd    <= '0;
        res_status <= TS_TIMED_OUT;
      end
      OP_SETTLE: begin
        res_cmd    <= '0;
        res_status <= settle_done ? TS_REACHED : TS_SETTLING;
      end
      OP_TGT: begin
        tgt <= tgt_clamped;
      end
      OP_RERR: begin
        rerr <= rerr_wide[19:0];
      end
      OP_FF: begin
        spd_sum <= prod_sh16[23:0];
      end
      OP_PROP: begin
        spd_sum <= spd_sum + prod_sh8[23:0];
      end
      OP_DIV100_FIX: begin
        spd_sum <= spd_sum + q100_val;
      end
      OP_CLAMP: begin
        if (spd_sum > spd_lim) begin
          spd_sum <= spd_lim;
        end else if (spd_sum < -spd_lim) begin
          spd_sum <= -spd_lim;
        end
      end
      OP_SLEW: begin
        res_cmd    <= slew_out[15:0];
        res_status <= TS_TURNING;
      end
      default: ;
    endcase

    if (op == OP_DIV10_MUL || op == OP_DIV100_MUL) begin
      div_neg <= div_src[59];
    end

    if (op == OP_TURN || op == OP_RERR || op == OP_FF || op == OP_PROP ||
        op == OP_DIV10_MUL || op == OP_IMUL || op == OP_DIV100_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      turn_command <= res_cmd;
      turn_status  <= res_status;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_accum_bounded: assert property (@(posedge clk) disable iff (rst)
    (rate_accum <= 20'(ACCUM_LIMIT)) && (rate_accum >= -20'(ACCUM_LIMIT)))
    else $error("integral left its clamp range");

  a_quiet_command: assert property (@(posedge clk) disable iff (rst)
    (out_valid && turn_status != TS_TURNING) |-> (turn_command == 16'sd0))
    else $error("nonzero command outside a turning beat");

  a_min_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && turn_status == TS_TURNING) |->
      (turn_command >= 16'(MIN_SPEED) || turn_command <= -16'(MIN_SPEED)))
    else $error("turning command below minimum speed");

endmodule

@@ rtl/cascaded_turn_to_angle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cascaded_turn_to_angle_ctrl: cascaded angle P / rate PI turn controller
// A tick with the heading error outside the settle threshold runs the whole
// sequence of controller states: the seven products of the angle loop, rate
// loop, feedforward and the two reciprocal divisions go one after another
// through a single shared 27x33 multiplier. Idle, settling, reached and
// timeout ticks skip those products. The result sits in an output
// register, so the next tick is taken while it waits; a tick stays in its
// last step only while the previous result is still held there.
// ----------------------------------------------------------------------------
module cascaded_turn_to_angle_ctrl #(
  parameter int TICK_MS      = 5,
  parameter int FILTER_SHIFT = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ctta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctta_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             start_turn,
  input  logic signed [15:0]               yaw_now,
  input  logic signed [18:0]               rate_now,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               turn_command,
  output logic [2:0]                       turn_status
);
  import ctta_pkg::*;

  dp_op_t    op;
  dp_flags_t flags;

  ctta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .op       (op)
  );

  ctta_dp #(
    .TICK_MS      (TICK_MS),
    .FILTER_SHIFT (FILTER_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .flags        (flags),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start_turn   (start_turn),
    .yaw_now      (yaw_now),
    .rate_now     (rate_now),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .turn_command (turn_command),
    .turn_status  (turn_status)
  );

endmodule
